/* rtl/sbmq_pkg.sv */
// Package for the shared-buffer multi-queue: word types, status and operation codes,
// and sequencer states.
// No dependencies. Used by shared_buffer_multi_queue and sbmq_checker.
package sbmq_pkg;

  // Field widths fixed by the word formats.
  localparam int QID_W    = 2;
  localparam int DIN_W    = 32;
  localparam int DOUT_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

  // Data returned with an underflow, and with every enqueue.
  localparam logic signed [DOUT_W-1:0] DOUT_UNDERFLOW = -32'sd1;
  localparam logic signed [DOUT_W-1:0] DOUT_ENQ       = 32'sd0;

  // Input word.
  typedef struct packed {
    logic                     operation;
    logic [QID_W-1:0]         queue_id;
    logic signed [DIN_W-1:0]  data_in;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [DOUT_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } seq_state_t;

endpackage

/* rtl/shared_buffer_multi_queue.sv */
// Several FIFO queues threaded as linked lists through one shared data store,
// with a free list of unused entries. Depends on sbmq_pkg.
//
//   Channel   Ports                     Handshake
//   input     in_word, start, busy      word taken at a clock edge with start high, busy low
//   result    out_word, out_strobe      one word per input, shown for one cycle
//
// An enqueue keeps busy high through the execute state after it is taken, a dequeue
// through the fetch and execute states, so a new word cannot be taken before the last
// is finished. The dequeue needs the fetch state because the link table has one read
// port, and its address (the queue head) comes out of the registered head-pointer
// memory in the cycle after accept. The result is strobed in the same cycle that busy
// falls; the receiver cannot stall it. Synchronous reset; no clearing pass: never-used
// entries above a fill mark implicitly link to the next entry.
module shared_buffer_multi_queue #(
  parameter int ENTRIES    = 16,
  parameter int QUEUES     = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sbmq_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output sbmq_pkg::out_word_t out_word
);

  // Pointer widths: PW holds the null pointer (ENTRIES), IW indexes the store.
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  // Memories.
  logic [IW-1:0]         head_mem [QUEUES];
  logic [IW-1:0]         tail_mem [QUEUES];
  logic [PW-1:0]         link_mem [ENTRIES];
  logic [DATA_WIDTH-1:0] data_mem [ENTRIES];

  // Control and item registers.
  sbmq_pkg::seq_state_t state_r, state_nxt;
  logic [PW-1:0]        free_head_r, free_head_nxt;
  logic [PW-1:0]        fill_r, fill_nxt;
  logic [QUEUES-1:0]    ne_r, ne_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  sbmq_pkg::out_word_t  out_word_r, out_word_nxt;
  logic                 op_r;
  logic [sbmq_pkg::QID_W-1:0] q_r;
  logic signed [sbmq_pkg::DIN_W-1:0] data_r;

  // Registered memory read data.
  logic [IW-1:0]         head_rd_r;
  logic [IW-1:0]         tail_rd_r;
  logic [PW-1:0]         link_rd_r;
  logic [DATA_WIDTH-1:0] data_rd_r;

  // Memory write controls.
  logic                  head_we, tail_we, link_we, data_we;
  logic [IW-1:0]         head_wd, tail_wd, link_wa, data_wa;
  logic [PW-1:0]         link_wd;
  logic [DATA_WIDTH-1:0] data_wd;

  logic          accept;
  logic          in_q_ok, q_ok;
  logic [QW-1:0] in_idx, q_idx;
  logic          enq_ok, deq_ok, slot_fresh, last_one;
  logic [PW-1:0] link_rd_addr;
  logic [63:0]   din_wide;
  logic signed [63:0] dout_wide;

  assign busy       = (state_r != sbmq_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  assign in_idx  = QW'(in_word.queue_id);
  assign in_q_ok = 32'(in_word.queue_id) < 32'(QUEUES);
  assign q_idx   = QW'(q_r);
  assign q_ok    = 32'(q_r) < 32'(QUEUES);

  // Item decode for the execute cycle.
  assign enq_ok     = q_ok && (free_head_r != NIL);
  assign deq_ok     = q_ok && ne_r[q_idx];
  assign slot_fresh = (free_head_r >= fill_r);
  assign last_one   = (head_rd_r == tail_rd_r);
  assign din_wide   = {32'd0, data_r};
  assign dout_wide  = 64'($signed(data_rd_r));

  // Link table is read at the free head on accept, at the queue head in fetch.
  assign link_rd_addr = (state_r == sbmq_pkg::ST_FETCH) ? PW'(head_rd_r) : free_head_r;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbmq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_word.operation == sbmq_pkg::OP_DEQ) ? sbmq_pkg::ST_FETCH
                                                              : sbmq_pkg::ST_EXEC;
        end
      end
      sbmq_pkg::ST_FETCH: state_nxt = sbmq_pkg::ST_EXEC;
      sbmq_pkg::ST_EXEC:  state_nxt = sbmq_pkg::ST_IDLE;
      default:            state_nxt = sbmq_pkg::ST_IDLE;
    endcase
  end

  // Pointer updates, memory writes and the result of the execute cycle.
  always_comb begin
    head_we        = 1'b0;
    tail_we        = 1'b0;
    link_we        = 1'b0;
    data_we        = 1'b0;
    head_wd        = free_head_r[IW-1:0];
    tail_wd        = free_head_r[IW-1:0];
    link_wa        = tail_rd_r;
    link_wd        = free_head_r;
    data_wa        = free_head_r[IW-1:0];
    data_wd        = din_wide[DATA_WIDTH-1:0];
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    ne_nxt         = ne_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    if (state_r == sbmq_pkg::ST_EXEC) begin
      out_strobe_nxt = 1'b1;
      if (op_r == sbmq_pkg::OP_ENQ) begin
        out_word_nxt.data_out = sbmq_pkg::DOUT_ENQ;
        out_word_nxt.status   = enq_ok ? sbmq_pkg::STAT_OK : sbmq_pkg::STAT_OVERFLOW;
        if (enq_ok) begin
          // Take the free head; a never-used entry links to the next one.
          if (slot_fresh) begin
            free_head_nxt = PW'(free_head_r + 1'b1);
            fill_nxt      = PW'(fill_r + 1'b1);
          end else begin
            free_head_nxt = link_rd_r;
          end
          // Append to the queue: new head if empty, else link from the old tail.
          head_we       = !ne_r[q_idx];
          link_we       = ne_r[q_idx];
          link_wa       = tail_rd_r;
          link_wd       = free_head_r;
          tail_we       = 1'b1;
          data_we       = 1'b1;
          ne_nxt[q_idx] = 1'b1;
        end
      end else begin
        out_word_nxt.data_out = deq_ok ? dout_wide[sbmq_pkg::DOUT_W-1:0]
                                       : sbmq_pkg::DOUT_UNDERFLOW;
        out_word_nxt.status   = deq_ok ? sbmq_pkg::STAT_OK : sbmq_pkg::STAT_UNDERFLOW;
        if (deq_ok) begin
          // Unlink the head; a single-entry queue runs empty.
          if (last_one) begin
            ne_nxt[q_idx] = 1'b0;
          end else begin
            head_we = 1'b1;
            head_wd = link_rd_r[IW-1:0];
          end
          // Push the entry onto the front of the free list.
          link_we       = 1'b1;
          link_wa       = head_rd_r;
          link_wd       = free_head_r;
          free_head_nxt = PW'(head_rd_r);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sbmq_pkg::ST_IDLE;
      free_head_r  <= '0;
      fill_r       <= '0;
      ne_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      fill_r       <= fill_nxt;
      ne_r         <= ne_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_word.operation;
      q_r    <= in_word.queue_id;
      data_r <= in_word.data_in;
    end
    out_word_r <= out_word_nxt;
  end

  // Head and tail pointer memories, read on accept of an in-range queue id.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[q_idx] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[q_idx] <= tail_wd;
    end
    if (accept && in_q_ok) begin
      head_rd_r <= head_mem[in_idx];
      tail_rd_r <= tail_mem[in_idx];
    end
  end

  // Link table: one write and one read per cycle.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (accept || (state_r == sbmq_pkg::ST_FETCH)) begin
      link_rd_r <= link_mem[link_rd_addr[IW-1:0]];
    end
  end

  // Data store, read at the queue head in fetch.
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_wa] <= data_wd;
    end
    if (state_r == sbmq_pkg::ST_FETCH) begin
      data_rd_r <= data_mem[head_rd_r];
    end
  end

endmodule

/* rtl/sbmq_checker.sv */
// Port-level checks for shared_buffer_multi_queue, and the bind that attaches them.
// Depends on sbmq_pkg.
module sbmq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input sbmq_pkg::out_word_t out_word
);

  // A taken word makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after a word was taken");

  // Every finished item is strobed just as busy drops.
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe)
    else $error("busy fell without a result word");

  // A result is only shown while the block is idle, and never twice in a row.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy ##1 !out_strobe)
    else $error("result strobe while busy or repeated");

  // An underflow always returns minus one.
  a_underflow_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_word.status == sbmq_pkg::STAT_UNDERFLOW)
      |-> (out_word.data_out == sbmq_pkg::DOUT_UNDERFLOW))
    else $error("underflow with wrong data");

  // An overflow always returns zero.
  a_overflow_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_word.status == sbmq_pkg::STAT_OVERFLOW)
      |-> (out_word.data_out == sbmq_pkg::DOUT_ENQ))
    else $error("overflow with wrong data");

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);
